// ----- hdl/stag_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes of the strided tensor address generator.
package stag_pkg;

  localparam int NUM_DIMS       = 4;
  localparam int DIM_WIDTH      = 16;
  localparam int STRIDE_WIDTH   = 16;
  localparam int ADDR_WIDTH     = 32;
  localparam int REG_WIDTH      = 16;
  localparam int CFG_REGS       = 2 * NUM_DIMS;
  localparam int CFG_IDX_WIDTH  = $clog2(CFG_REGS);
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = CFG_IDX_WIDTH + 2;

  // Register map: sizes first, outermost dimension at the lowest index, then strides.
  localparam int CFG_SIZE_BASE   = 0;
  localparam int CFG_STRIDE_BASE = NUM_DIMS;

  typedef enum logic {
    KIND_RESTART = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    kind_t           kind;
    logic [31:0]     start_offset;
  } cmd_t;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] pos_0;
    logic [15:0] pos_1;
    logic [15:0] pos_2;
    logic [15:0] pos_3;
    logic        done_res;
  } rsp_t;

  // Control handed to every cell of the counter chain.
  typedef struct packed {
    logic clear;
    logic token_in;
  } cell_ctrl_t;

  // Status a cell reports back while it holds the carry token.
  typedef struct packed {
    logic                  active;
    logic                  wrap;
    logic                  carry;
    logic [ADDR_WIDTH-1:0] delta;
  } cell_stat_t;

endpackage

// ----- hdl/stag_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and response words.
interface stag_cmd_if;
  logic            valid;
  logic            ready;
  stag_pkg::cmd_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stag_rsp_if;
  logic            valid;
  logic            ready;
  stag_pkg::rsp_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/stag_cfg.sv -----
`timescale 1ns / 1ps
// APB register file holding the dimension sizes and strides.
module stag_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stag_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [stag_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [stag_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready,
  output logic [stag_pkg::DIM_WIDTH-1:0]      size [stag_pkg::NUM_DIMS],
  output logic [stag_pkg::STRIDE_WIDTH-1:0]   stride [stag_pkg::NUM_DIMS]
);

  logic [stag_pkg::REG_WIDTH-1:0]     regs [stag_pkg::CFG_REGS];
  logic [stag_pkg::CFG_IDX_WIDTH-1:0] idx;
  logic                               wr_en;

  assign idx    = paddr[stag_pkg::APB_ADDR_WIDTH-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = stag_pkg::APB_DATA_WIDTH'(regs[idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < stag_pkg::CFG_REGS; i++) begin
        regs[i] <= (i < stag_pkg::CFG_STRIDE_BASE) ? stag_pkg::REG_WIDTH'(1)
                                                   : '0;
      end
    end else if (wr_en) begin
      regs[idx] <= pwdata[stag_pkg::REG_WIDTH-1:0];
    end
  end

  always_comb begin
    for (int d = 0; d < stag_pkg::NUM_DIMS; d++) begin
      size[d]   = regs[stag_pkg::CFG_SIZE_BASE + d];
      stride[d] = regs[stag_pkg::CFG_STRIDE_BASE + d];
    end
  end

endmodule

// ----- hdl/stag_cell.sv -----
`timescale 1ns / 1ps
// One dimension of the walk: position counter, wrap test and address step.
module stag_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [stag_pkg::DIM_WIDTH-1:0]    size,
  input  logic [stag_pkg::STRIDE_WIDTH-1:0] stride,
  input  stag_pkg::cell_ctrl_t              ctrl,
  output logic [stag_pkg::DIM_WIDTH-1:0]    pos,
  output stag_pkg::cell_stat_t              stat
);

  localparam int PROD_WIDTH = stag_pkg::DIM_WIDTH + stag_pkg::STRIDE_WIDTH;

  logic                              token;
  logic [stag_pkg::DIM_WIDTH-1:0]    size_eff;
  logic [stag_pkg::DIM_WIDTH:0]      pos_inc;
  logic                              wrap;
  logic [PROD_WIDTH-1:0]             wrap_amount;
  logic [stag_pkg::ADDR_WIDTH-1:0]   stride_ext;

  // A size of zero behaves as a size of one.
  assign size_eff   = (size == '0) ? stag_pkg::DIM_WIDTH'(1) : size;
  assign pos_inc    = {1'b0, pos} + (stag_pkg::DIM_WIDTH + 1)'(1);
  assign wrap       = pos_inc >= {1'b0, size_eff};
  assign stride_ext = stag_pkg::ADDR_WIDTH'(stride);

  // The full span of this dimension is kept ready in a register, so the
  // address step needs only one subtract while the token is here.
  always_ff @(posedge clk) begin
    wrap_amount <= PROD_WIDTH'(size_eff) * PROD_WIDTH'(stride);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= 1'b0;
    end else begin
      token <= ctrl.token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (ctrl.clear) begin
      pos <= '0;
    end else if (token) begin
      pos <= wrap ? '0 : pos_inc[stag_pkg::DIM_WIDTH-1:0];
    end
  end

  always_comb begin
    stat.active = token;
    stat.wrap   = wrap;
    stat.carry  = token && wrap;
    if (!token) begin
      stat.delta = '0;
    end else if (wrap) begin
      stat.delta = stride_ext - stag_pkg::ADDR_WIDTH'(wrap_amount);
    end else begin
      stat.delta = stride_ext;
    end
  end

endmodule

// ----- hdl/strided_tensor_address_generator.sv -----
`timescale 1ns / 1ps
// Top level of the strided tensor address generator.
//
// Usage: words arrive on the cmd channel (valid/ready). A restart word loads
// start_offset as the address, zeroes every position and clears done; an
// advance word steps the walk one element in row-major order. Every
// accepted word yields exactly one response word on the rsp channel with
// the address, the four positions and the done flag after that step.
// Sizes and strides are written over the APB port while no word is in work.
//
// Timing: the carry travels outward through a chain of four counter cells,
// one cell per cycle. A restart, or an advance once the walk is finished,
// goes from acceptance straight to ST_EMIT; any other advance passes ST_WALK
// until a counter does not wrap or the outermost wraps. ST_EMIT loads the
// response register once it is free. One word is in work at a time.
// The response register decouples the two sides: a new command is taken
// while an earlier response still waits, and if the receiver stalls the
// next response is held back until the register frees up.
// Reset (rst, synchronous) zeroes positions and address, sets done, sizes
// to one and strides to zero; no walk runs until the first restart.
module strided_tensor_address_generator (
  input  logic                                clk,
  input  logic                                rst,
  stag_cmd_if.sink                            cmd,
  stag_rsp_if.source                          rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stag_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [stag_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [stag_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);

  localparam int NUM_DIMS = stag_pkg::NUM_DIMS;

  logic [stag_pkg::DIM_WIDTH-1:0]    size [NUM_DIMS];
  logic [stag_pkg::STRIDE_WIDTH-1:0] stride [NUM_DIMS];
  logic [stag_pkg::DIM_WIDTH-1:0]    pos [NUM_DIMS];
  stag_pkg::cell_ctrl_t              ctrl [NUM_DIMS];
  stag_pkg::cell_stat_t              stat [NUM_DIMS];

  stag_pkg::state_t                  state;
  stag_pkg::state_t                  state_next;
  logic [stag_pkg::ADDR_WIDTH-1:0]   address;
  logic                              finished;
  logic                              rsp_valid;
  stag_pkg::rsp_t                    rsp_word;

  logic                              cmd_ready;
  logic                              accept;
  logic                              clear_all;
  logic                              start_walk;
  logic                              load_out;
  logic                              out_free;
  logic                              walk_end;
  logic                              walk_fin;
  logic [stag_pkg::ADDR_WIDTH-1:0]   delta_sum;

  stag_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size    (size),
    .stride  (stride)
  );

  // The token enters at the innermost cell and moves outward on each wrap.
  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
    assign ctrl[d].clear = clear_all;
    if (d == NUM_DIMS - 1) begin : g_inner
      assign ctrl[d].token_in = start_walk;
    end else begin : g_outer
      assign ctrl[d].token_in = stat[d+1].carry;
    end

    stag_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .size   (size[d]),
      .stride (stride[d]),
      .ctrl   (ctrl[d]),
      .pos    (pos[d]),
      .stat   (stat[d])
    );
  end

  // Only the cell holding the token gives a nonzero step, so OR merges them.
  // The walk ends where a counter does not wrap, or when the outermost wraps.
  always_comb begin
    delta_sum = '0;
    walk_end  = stat[0].active;
    for (int d = 0; d < NUM_DIMS; d++) begin
      delta_sum = delta_sum | stat[d].delta;
      walk_end  = walk_end | (stat[d].active && !stat[d].wrap);
    end
    walk_fin = stat[0].carry;
  end

  assign out_free   = !rsp_valid || rsp.ready;
  assign accept     = cmd.valid && cmd_ready;
  assign clear_all  = accept && cmd.data.kind == stag_pkg::KIND_RESTART;
  assign start_walk = accept && cmd.data.kind == stag_pkg::KIND_ADVANCE && !finished;

  always_comb begin
    state_next = state;
    case (state)
      stag_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd.data.kind == stag_pkg::KIND_RESTART || finished) begin
            state_next = stag_pkg::ST_EMIT;
          end else begin
            state_next = stag_pkg::ST_WALK;
          end
        end
      end
      stag_pkg::ST_WALK: begin
        if (walk_end) begin
          state_next = stag_pkg::ST_EMIT;
        end
      end
      stag_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = stag_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stag_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      stag_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
      end
      stag_pkg::ST_WALK: begin
        cmd_ready = 1'b0;
      end
      stag_pkg::ST_EMIT: begin
        load_out = out_free;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stag_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address  <= '0;
      finished <= 1'b1;
    end else if (clear_all) begin
      address  <= stag_pkg::ADDR_WIDTH'(cmd.data.start_offset);
      finished <= 1'b0;
    end else if (state == stag_pkg::ST_WALK) begin
      address <= address + delta_sum;
      if (walk_fin) begin
        finished <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp_word.address  <= address;
      rsp_word.pos_0    <= pos[0];
      rsp_word.pos_1    <= pos[1];
      rsp_word.pos_2    <= pos[2];
      rsp_word.pos_3    <= pos[3];
      rsp_word.done_res <= finished;
    end
  end

  assign cmd.ready = cmd_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_word;

endmodule

// ----- hdl/stag_chk.sv -----
`timescale 1ns / 1ps
// Port-level checks of the address generator, bound to the top level.
module stag_chk (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input stag_pkg::rsp_t rsp_data
);

  // A stalled response word stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response word changed while stalled");

  // Only one command word is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while another is in work");

  // A finished walk has every counter back at zero.
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.done_res |->
      rsp_data.pos_0 == '0 && rsp_data.pos_1 == '0 &&
      rsp_data.pos_2 == '0 && rsp_data.pos_3 == '0)
    else $error("done reported with nonzero position");

  // Reset drops any pending response.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind strided_tensor_address_generator stag_chk u_stag_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- tb/sv/strided_tensor_address_generator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the strided tensor address generator.
module strided_tensor_address_generator_tb;
  import stag_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_CYCLES   = 20;
  localparam int LONG_HOLD      = 150;
  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_WORDS    = 113;
  localparam int TIMEOUT_CYCLES = 800_000;
  localparam int DIR_ROW_COUNT  = 32;
  localparam int MAX_PRINTS     = 50;

  // Register map, sizes first and then strides, outermost dimension lowest.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_SIZE_0   = CFG_SIZE_BASE,
    REG_SIZE_1,
    REG_SIZE_2,
    REG_SIZE_3,
    REG_STRIDE_0 = CFG_STRIDE_BASE,
    REG_STRIDE_1,
    REG_STRIDE_2,
    REG_STRIDE_3
  } reg_idx_e;

  // A row of the directed table either sends a command word or writes a register.
  typedef enum logic {
    ROW_WORD,
    ROW_WRITE
  } row_op_e;

  typedef struct packed {
    row_op_e     op;
    kind_t       kind;
    reg_idx_e    reg_idx;
    logic [31:0] value;
    logic        has_want;
    rsp_t        want;
  } dir_row_t;

  localparam rsp_t NO_RSP = '0;

  // The directed part. Responses are spelled out only where they are obvious;
  // the remaining rows are checked against the walk predictor.
  localparam dir_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
    // Right after reset no walk runs, so an advance reports the cleared state with done set.
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0000_0000, 1'b1,
      rsp_t'{32'h0000_0000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
    // A restart at the top of the address space.
    '{ROW_WORD,  KIND_RESTART, REG_SIZE_0,   32'hFFFF_FFFF, 1'b1,
      rsp_t'{32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    // With every size at one, a single advance wraps all four counters and finishes.
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0000_0000, 1'b1,
      rsp_t'{32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
    // Once finished, an advance changes nothing.
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0000_0000, 1'b1,
      rsp_t'{32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1}},
    // A 2 x 2 x 0 x 3 walk. Upper data bits must be dropped, and the size of zero
    // behaves as one. The large strides push the address across the wrap point.
    '{ROW_WRITE, KIND_ADVANCE, REG_SIZE_3,   32'hABCD_0003, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_STRIDE_3, 32'hFFFF_FFFF, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_SIZE_2,   32'h0000_0000, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_STRIDE_2, 32'h0000_1234, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_SIZE_1,   32'h5A5A_0002, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_STRIDE_1, 32'h0000_0100, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_SIZE_0,   32'h0000_0002, 1'b0, NO_RSP},
    '{ROW_WRITE, KIND_ADVANCE, REG_STRIDE_0, 32'h0000_8000, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_RESTART, REG_SIZE_0,   32'hFFFF_FFF0, 1'b1,
      rsp_t'{32'hFFFF_FFF0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    // Twelve elements: eleven advances reach the last one, the twelfth finishes
    // the walk and the thirteenth runs into the finished state.
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    // Largest inner size with the largest stride: the first step wraps the address.
    '{ROW_WRITE, KIND_ADVANCE, REG_SIZE_3,   32'h0000_FFFF, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_RESTART, REG_SIZE_0,   32'hFFFF_FFFF, 1'b1,
      rsp_t'{32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0}},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0000_0000, 1'b1,
      rsp_t'{32'h0000_FFFE, 16'd0, 16'd0, 16'd0, 16'd1, 1'b0}},
    // Shrinking the inner size to the current position in the middle of a walk
    // forces the counter to wrap on the next advance.
    '{ROW_WRITE, KIND_ADVANCE, REG_SIZE_3,   32'h0000_0001, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP},
    '{ROW_WORD,  KIND_ADVANCE, REG_SIZE_0,   32'h0, 1'b0, NO_RSP}
  };

  logic clk;
  logic rst;

  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  stag_cmd_if cmd_ch ();
  stag_rsp_if rsp_ch ();

  strided_tensor_address_generator uut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the registers and of the walk state.
  logic [REG_WIDTH-1:0]  dim_size   [NUM_DIMS];
  logic [REG_WIDTH-1:0]  dim_stride [NUM_DIMS];
  logic [DIM_WIDTH-1:0]  walk_pos   [NUM_DIMS];
  logic [ADDR_WIDTH-1:0] walk_addr;
  logic                  walk_done;

  // Response words still owed by the block, oldest first.
  rsp_t predicted_rsp [$];

  bit quiet;     // No idle cycles on either side while set.
  bit hold_req;  // Asks the receiver for one long stall.

  int mismatches;
  int rsp_checked;
  int restarts;
  int advances;
  int walks_finished;
  int reg_writes;
  int settings;
  int long_holds;

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Start offsets that favor both ends of the address space.
  function automatic logic [31:0] pick_offset();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      default: return $urandom();
    endcase
  endfunction

  // One step of the row-major walk. The innermost counter is stepped first and
  // every wrap carries one dimension outward; a carry out of the outermost
  // dimension finishes the walk.
  function automatic rsp_t step_walk(kind_t kind, logic [31:0] offset);
    logic [16:0] next_pos;
    logic [31:0] eff_size;
    rsp_t        r;
    bit          carry;
    int          d;
    if (kind == KIND_RESTART) begin
      for (d = 0; d < NUM_DIMS; d++) walk_pos[d] = '0;
      walk_addr = offset;
      walk_done = 1'b0;
    end else if (!walk_done) begin
      carry = 1'b1;
      for (d = NUM_DIMS - 1; d >= 0 && carry; d--) begin
        // A size of zero counts as one.
        eff_size = (dim_size[d] == '0) ? 32'd1 : 32'(dim_size[d]);
        next_pos = {1'b0, walk_pos[d]} + 17'd1;
        walk_addr = walk_addr + 32'(dim_stride[d]);
        if (32'(next_pos) < eff_size) begin
          walk_pos[d] = next_pos[DIM_WIDTH-1:0];
          carry = 1'b0;
        end else begin
          walk_pos[d] = '0;
          walk_addr = walk_addr - eff_size * 32'(dim_stride[d]);
        end
      end
      if (carry) begin
        walk_done = 1'b1;
        walks_finished++;
      end
    end
    r.address  = walk_addr;
    r.pos_0    = walk_pos[0];
    r.pos_1    = walk_pos[1];
    r.pos_2    = walk_pos[2];
    r.pos_3    = walk_pos[3];
    r.done_res = walk_done;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one command word, after a random gap, until the block takes it. The
  // expectation is queued at the edge of acceptance. valid stays high when no
  // gap comes before the next word.
  task automatic send_word(input kind_t kind, input logic [31:0] offset,
                           input logic has_want, input rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= cmd_t'{kind, offset};
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = step_walk(kind, offset);
    predicted_rsp.push_back(has_want ? want : predicted);
    if (kind == KIND_RESTART) restarts++;
    else advances++;
  endtask

  // Drops valid and waits until every owed response has come back and then
  // settles, so that register writes only happen while the block is idle.
  task automatic wait_idle();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (predicted_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write followed by a read of the same register. The read must return
  // the value with the bits above the register width dropped.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    logic [31:0] kept;
    kept = value & ((32'd1 << REG_WIDTH) - 32'd1);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < CFG_STRIDE_BASE) dim_size[idx - CFG_SIZE_BASE] = kept[REG_WIDTH-1:0];
    else dim_stride[idx - CFG_STRIDE_BASE] = kept[REG_WIDTH-1:0];
    reg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) report_mismatch("register read back", prdata, kept);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Response side: random stalls, and one long hold whenever one is asked
  // for. The hold is counted here, so the sender keeps offering words and the
  // block backs up until it stops taking them.
  initial begin : rsp_sink
    int stall;
    int hold;
    stall = 0;
    hold  = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold = LONG_HOLD - 1;
        long_holds++;
        rsp_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Every accepted response word is compared with the oldest expectation.
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (predicted_rsp.size() == 0) begin
        report_mismatch("unexpected response address", rsp_ch.data.address, 32'h0);
      end else begin
        want = predicted_rsp.pop_front();
        rsp_checked++;
        if (rsp_ch.data.address !== want.address)
          report_mismatch("address", rsp_ch.data.address, want.address);
        if (rsp_ch.data.pos_0 !== want.pos_0)
          report_mismatch("pos_0", 32'(rsp_ch.data.pos_0), 32'(want.pos_0));
        if (rsp_ch.data.pos_1 !== want.pos_1)
          report_mismatch("pos_1", 32'(rsp_ch.data.pos_1), 32'(want.pos_1));
        if (rsp_ch.data.pos_2 !== want.pos_2)
          report_mismatch("pos_2", 32'(rsp_ch.data.pos_2), 32'(want.pos_2));
        if (rsp_ch.data.pos_3 !== want.pos_3)
          report_mismatch("pos_3", 32'(rsp_ch.data.pos_3), 32'(want.pos_3));
        if (rsp_ch.data.done_res !== want.done_res)
          report_mismatch("done_res", 32'(rsp_ch.data.done_res), 32'(want.done_res));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Timed out with %0d response words still owed.", predicted_rsp.size());
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int          i;
    int          n;
    logic [15:0] sz;
    logic [15:0] st;

    // Every input known from time zero, with reset held high.
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    mismatches     = 0;
    rsp_checked    = 0;
    restarts       = 0;
    advances       = 0;
    walks_finished = 0;
    reg_writes     = 0;
    settings       = 1;
    long_holds     = 0;

    // Reset state of the predictor: sizes one, strides zero, no walk running.
    for (i = 0; i < NUM_DIMS; i++) begin
      dim_size[i]   = 16'd1;
      dim_stride[i] = 16'd0;
      walk_pos[i]   = '0;
    end
    walk_addr = '0;
    walk_done = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    for (i = 0; i < DIR_ROW_COUNT; i++) begin
      if (DIR_ROWS[i].op == ROW_WRITE) begin
        wait_idle();
        write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].value);
      end else begin
        send_word(DIR_ROWS[i].kind, DIR_ROWS[i].value, DIR_ROWS[i].has_want,
                  DIR_ROWS[i].want);
      end
    end

    // Random part. Each phase writes a new setting and then runs mostly long
    // walks of advances, with a restart now and then. A walk is often carried
    // over from the previous setting, which checks the wrap of a counter that
    // is already past its new size.
    for (p = 0; p < PHASE_COUNT; p++) begin
      wait_idle();
      quiet = (p % 4 == 3);
      for (i = 0; i < NUM_DIMS; i++) begin
        case (p % 5)
          0: begin
            // Tiny tensors that finish quickly.
            sz = 16'($urandom_range(1, 3));
            st = 16'($urandom());
          end
          1: begin
            // Sizes of zero to two with the extreme strides.
            sz = 16'($urandom_range(0, 2));
            st = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          end
          2: begin
            sz = 16'hFFFF;
            st = 16'hFFFF;
          end
          3: begin
            // Longer rows in the innermost dimension only.
            sz = (i == NUM_DIMS - 1) ? 16'($urandom_range(1, 40))
                                     : 16'($urandom_range(1, 4));
            st = 16'($urandom());
          end
          default: begin
            sz = 16'd1;
            st = 16'($urandom());
          end
        endcase
        write_reg(reg_idx_e'(CFG_SIZE_BASE + i), {16'($urandom()), sz});
        write_reg(reg_idx_e'(CFG_STRIDE_BASE + i), {16'($urandom()), st});
      end
      settings++;

      // Long receiver holds while the sender keeps pushing.
      if (p == 1 || p == 6) hold_req = 1'b1;

      if ($urandom_range(0, 3) != 0) send_word(KIND_RESTART, pick_offset(), 1'b0, NO_RSP);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(0, 99) < 3) send_word(KIND_RESTART, pick_offset(), 1'b0, NO_RSP);
        else send_word(KIND_ADVANCE, $urandom(), 1'b0, NO_RSP);
      end
    end

    // Let every owed response come back, then give the block time to show any
    // stray extra word.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d command words (%0d restarts, %0d advances) over %0d settings.",
             restarts + advances, restarts, advances, settings);
    $display("%0d walks ran to the end, %0d responses checked, %0d registers read back, %0d long holds.",
             walks_finished, rsp_checked, reg_writes, long_holds);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/stag_pkg.sv
hdl/stag_if.sv
hdl/stag_cfg.sv
hdl/stag_cell.sv
hdl/strided_tensor_address_generator.sv
hdl/stag_chk.sv
tb/sv/strided_tensor_address_generator_tb.sv
